@@ hw/rtl/sha1md_pkg.sv @@
// shared types and constants for the sha-1 digest block
// used by sha1md_ctrl, sha1md_dp and sha1_message_digest; no dependencies
`default_nettype none

package sha1md_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam int NUM_ROUNDS = 80;
  localparam int NUM_WORDS  = 5;

  // round function groups, twenty rounds each
  typedef enum logic [1:0] {
    GRP_CH     = 2'd0,
    GRP_PAR0   = 2'd1,
    GRP_MAJ    = 2'd2,
    GRP_PAR1   = 2'd3
  } round_grp_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_LOAD  = 3'd1,
    ST_ROUND = 3'd2,
    ST_ADD   = 3'd3,
    ST_PAD   = 3'd4,
    ST_LEN   = 3'd5,
    ST_EMIT  = 3'd6
  } state_t;

  // where to go once a block compression finishes
  typedef enum logic [1:0] {
    PH_BLOCK = 2'd0,
    PH_TAIL  = 2'd1,
    PH_EXTRA = 2'd2,
    PH_LAST  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       take_byte;
    logic       load_vars;
    logic       round;
    round_grp_t round_grp;
    logic       add_chain;
    logic       pad_fill;
    logic       pad_len;
    logic       len_fill;
    logic       restart;
    logic [2:0] word_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic block_full;
    logic tail_long;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/sha1md_dp.sv @@
// sha-1 datapath: chaining values, working variables, message window,
// byte count and bit length; driven by commands from sha1md_ctrl, uses sha1md_pkg
`default_nettype none

module sha1md_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sha1md_pkg::dp_cmd_t    cmd,
  input  wire logic [7:0]             data_byte,
  output sha1md_pkg::dp_status_t      status,
  output logic [31:0]                 digest_word
);
  import sha1md_pkg::*;

  logic [31:0] chain [NUM_WORDS];
  logic [31:0] va, vb, vc, vd, ve;
  logic [31:0] window [16];
  logic [5:0]  byte_count;
  logic [63:0] bit_length;

  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] temp;
  logic [31:0] sched_next;
  logic [31:0] pad_word [16];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  always_comb begin
    case (cmd.round_grp)
      GRP_CH: begin
        f_val = (vb & vc) | (~vb & vd);
        k_val = K0;
      end
      GRP_PAR0: begin
        f_val = vb ^ vc ^ vd;
        k_val = K1;
      end
      GRP_MAJ: begin
        f_val = (vb & vc) | (vb & vd) | (vc & vd);
        k_val = K2;
      end
      default: begin
        f_val = vb ^ vc ^ vd;
        k_val = K3;
      end
    endcase
    temp = rol(va, 5) + f_val + ve + k_val + window[0];
    // window holds w[t..t+15]; next word w[t+16]
    sched_next = rol(window[13] ^ window[8] ^ window[2] ^ window[0], 1);
  end

  // 0x80 at the current position, zeros after it
  always_comb begin
    for (int w = 0; w < 16; w++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(w * 4 + b) < byte_count) begin
          pad_word[w][31 - 8 * b -: 8] = window[w][31 - 8 * b -: 8];
        end else if (6'(w * 4 + b) == byte_count) begin
          pad_word[w][31 - 8 * b -: 8] = PAD_MARK;
        end else begin
          pad_word[w][31 - 8 * b -: 8] = 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      window[byte_count[5:2]][5'd24 - {byte_count[1:0], 3'b000} +: 8] <= data_byte;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i + 1];
      end
      window[15] <= sched_next;
    end else if (cmd.pad_fill) begin
      for (int i = 0; i < 14; i++) begin
        window[i] <= pad_word[i];
      end
      window[14] <= cmd.pad_len ? bit_length[63:32] : pad_word[14];
      window[15] <= cmd.pad_len ? bit_length[31:0] : pad_word[15];
    end else if (cmd.len_fill) begin
      for (int i = 0; i < 14; i++) begin
        window[i] <= '0;
      end
      window[14] <= bit_length[63:32];
      window[15] <= bit_length[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (cmd.round) begin
      va <= temp;
      vb <= va;
      vc <= rol(vb, 30);
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      chain[0]   <= IV0;
      chain[1]   <= IV1;
      chain[2]   <= IV2;
      chain[3]   <= IV3;
      chain[4]   <= IV4;
      byte_count <= '0;
      bit_length <= '0;
    end else begin
      if (cmd.add_chain) begin
        chain[0] <= chain[0] + va;
        chain[1] <= chain[1] + vb;
        chain[2] <= chain[2] + vc;
        chain[3] <= chain[3] + vd;
        chain[4] <= chain[4] + ve;
      end
      if (cmd.take_byte) begin
        byte_count <= byte_count + 6'd1;
        bit_length <= bit_length + 64'd8;
      end
    end
  end

  always_comb begin
    status.block_full = (byte_count == 6'd63);
    status.tail_long  = (byte_count >= 6'd56);
    case (cmd.word_sel)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      3'd4:    digest_word = chain[4];
      default: digest_word = chain[0];
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/sha1md_ctrl.sv @@
// sha-1 sequencer: request handshakes, round counting, padding and digest output
// steers sha1md_dp through dp_cmd_t; uses sha1md_pkg
`default_nettype none

module sha1md_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_valid,
  output logic                        s_ready,
  input  wire logic                   s_has_byte,
  input  wire logic                   s_last,
  output logic                        m_valid,
  input  wire logic                   m_ready,
  output logic [2:0]                  m_index,
  output logic                        m_last,
  input  wire sha1md_pkg::dp_status_t status,
  output sha1md_pkg::dp_cmd_t         cmd
);
  import sha1md_pkg::*;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [6:0] round_count, round_count_next;
  logic [2:0] word_idx, word_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_BLOCK;
      round_count <= '0;
      word_idx    <= '0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      round_count <= round_count_next;
      word_idx    <= word_idx_next;
    end
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    round_count_next = round_count;
    word_idx_next    = word_idx;
    cmd              = '0;
    cmd.word_sel     = word_idx;
    s_ready          = 1'b0;
    m_valid          = 1'b0;
    m_index          = word_idx;
    m_last           = (word_idx == 3'(NUM_WORDS - 1));

    if (round_count < 7'd20) begin
      cmd.round_grp = GRP_CH;
    end else if (round_count < 7'd40) begin
      cmd.round_grp = GRP_PAR0;
    end else if (round_count < 7'd60) begin
      cmd.round_grp = GRP_MAJ;
    end else begin
      cmd.round_grp = GRP_PAR1;
    end

    case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.take_byte = s_has_byte;
          if (s_has_byte && status.block_full) begin
            phase_next = s_last ? PH_TAIL : PH_BLOCK;
            state_next = ST_LOAD;
          end else if (s_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_vars    = 1'b1;
        round_count_next = '0;
        state_next       = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (round_count == 7'(NUM_ROUNDS - 1)) begin
          round_count_next = '0;
          state_next       = ST_ADD;
        end else begin
          round_count_next = round_count + 7'd1;
        end
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
        case (phase)
          PH_BLOCK: state_next = ST_IDLE;
          PH_TAIL:  state_next = ST_PAD;
          PH_EXTRA: state_next = ST_LEN;
          default:  state_next = ST_EMIT;
        endcase
      end
      ST_PAD: begin
        // a long tail leaves no room for the length in this block
        cmd.pad_fill = 1'b1;
        cmd.pad_len  = !status.tail_long;
        phase_next   = status.tail_long ? PH_EXTRA : PH_LAST;
        state_next   = ST_LOAD;
      end
      ST_LEN: begin
        cmd.len_fill = 1'b1;
        phase_next   = PH_LAST;
        state_next   = ST_LOAD;
      end
      ST_EMIT: begin
        m_valid = 1'b1;
        if (m_ready) begin
          if (m_last) begin
            cmd.restart   = 1'b1;
            word_idx_next = '0;
            phase_next    = PH_BLOCK;
            state_next    = ST_IDLE;
          end else begin
            word_idx_next = word_idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/sha1_message_digest.sv @@
// SHA-1 message digest, one message byte per request on the input stream.
//
// Input stream s_axis: tdata carries the byte, tuser says the byte is part of
// the message (0 for a bare end marker, which lets an empty message be hashed),
// tlast closes the message. Output stream m_axis: five requests per message,
// tdata is the digest word h0..h4, tuser its index, tlast marks h4.
//
// A byte that does not complete a 64-byte block leaves input ready. A byte
// that completes a block stalls input while the block compresses: a load
// step, the rounds through the single round unit, and a step to fold into
// the chaining values. Message end adds a fill step and a compression for
// each padded block (one or two blocks), then the five digest words, one per
// cycle while m_axis_tready is high.
//
// Input is not taken while a block compresses or the digest is sent. When the
// receiver stalls, the current digest word holds and the block waits. After
// the last word, chaining values return to the initial constants. Reset
// (rst, synchronous) does the same and empties any partial message.
// Depends on sha1md_pkg, sha1md_ctrl and sha1md_dp.
`default_nettype none

module sha1_message_digest (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // has_byte
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // digest_word
  output logic [2:0]       m_axis_tuser,   // word_index
  output logic             m_axis_tlast    // last_word
);
  import sha1md_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_has_byte (s_axis_tuser),
    .s_last     (s_axis_tlast),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_index    (m_axis_tuser),
    .m_last     (m_axis_tlast),
    .status     (status),
    .cmd        (cmd)
  );

  sha1md_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_axis_tdata),
    .status      (status),
    .digest_word (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench for sha1_message_digest: table-driven directed requests, then random messages
// checked word by word against a sha-1 model kept here; needs sha1md_pkg and the rtl only
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1md_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int NUM_ITEMS     = 210;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 200;
  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sha1_message_digest u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // data_byte
    .s_axis_tuser  (s_axis_tuser),   // has_byte
    .s_axis_tlast  (s_axis_tlast),   // end_of_message
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // digest_word
    .m_axis_tuser  (m_axis_tuser),   // word_index
    .m_axis_tlast  (m_axis_tlast)    // last_word
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         has;
    logic         last;
    logic         typed;
    logic [159:0] digest;
  } req_row_t;

  // directed requests; typed rows carry a known digest
  req_row_t dir_rows [16] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message right after reset
    '{8'hA5, 1'b0, 1'b0, 1'b0, 160'd0},         // idle request, data ignored
    '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // bare end marker with junk data
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h63, 1'b1, 1'b1, 1'b0, 160'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'd0},         // single zero byte
    '{8'hFF, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h5A, 1'b0, 1'b0, 1'b0, 160'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'hFE, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 160'd0},         // bare end after bytes
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}    // chaining values back at iv
  };

  // sha-1 model state
  logic [31:0] chain [5];
  logic [31:0] sched [16];
  logic [5:0]  blk_bytes;
  logic [63:0] bit_len;
  logic [31:0] digest_out [5];

  digest_word_t exp_words [$];
  digest_word_t want;
  int errors = 0;
  int msgs_done;
  int words_checked = 0;
  int items_sent;
  int idle_cycles = 0;
  bit hold_req;
  bit hold_done;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void load_iv();
    chain[0] = IV0;
    chain[1] = IV1;
    chain[2] = IV2;
    chain[3] = IV3;
    chain[4] = IV4;
  endfunction

  function automatic void put_byte(input int pos, input logic [7:0] b);
    sched[pos >> 2][(24 - 8 * (pos & 3)) +: 8] = b;
  endfunction

  function automatic void compress();
    logic [31:0] a, b, c, d, e, f, k, tmp;
    round_grp_t grp;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int t = 0; t < NUM_ROUNDS; t++) begin
      if (t >= 16)
        sched[t & 15] = rotl(sched[(t - 3) & 15] ^ sched[(t - 8) & 15]
                             ^ sched[(t - 14) & 15] ^ sched[t & 15], 1);
      grp = round_grp_t'(t / 20);
      case (grp)
        GRP_CH: begin
          f = (b & c) | (~b & d);
          k = K0;
        end
        GRP_PAR0: begin
          f = b ^ c ^ d;
          k = K1;
        end
        GRP_MAJ: begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end
        default: begin
          f = b ^ c ^ d;
          k = K3;
        end
      endcase
      tmp = rotl(a, 5) + f + e + k + sched[t & 15];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = tmp;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // absorbs one request; returns 1 when digest_out holds a finished digest
  function automatic bit sha1_absorb(input logic [7:0] data, input logic has,
                                     input logic last);
    if (has) begin
      put_byte(blk_bytes, data);
      bit_len += 64'd8;
      blk_bytes += 6'd1;
      if (blk_bytes == 6'd0)
        compress();
    end
    if (!last)
      return 1'b0;
    put_byte(blk_bytes, PAD_MARK);
    for (int p = blk_bytes + 1; p < 64; p++)
      put_byte(p, 8'h00);
    // long tail: length goes into an extra block
    if (blk_bytes >= 6'd56) begin
      compress();
      for (int i = 0; i < 16; i++)
        sched[i] = 32'd0;
    end
    sched[14] = bit_len[63:32];
    sched[15] = bit_len[31:0];
    compress();
    for (int i = 0; i < NUM_WORDS; i++)
      digest_out[i] = chain[i];
    load_iv();
    blk_bytes = 6'd0;
    bit_len = 64'd0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  task automatic send_req(input logic [7:0] data, input logic has, input logic last,
                          input logic typed, input logic [159:0] known);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    items_sent++;
    if (sha1_absorb(data, has, last)) begin
      msgs_done++;
      for (int i = 0; i < NUM_WORDS; i++)
        exp_words.push_back('{typed ? known[159 - 32 * i -: 32] : digest_out[i],
                              3'(i), i == NUM_WORDS - 1});
    end
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len);
    bit bare_end;
    bare_end = (len == 0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      // some noise: idle requests with junk data between bytes
      if ($urandom_range(0, 9) == 0)
        send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 160'd0);
      send_req(8'($urandom_range(0, 255)), 1'b1, !bare_end && (i == len - 1),
               1'b0, 160'd0);
    end
    if (bare_end)
      send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 160'd0);
  endtask

  // receiver: random stalls, long ready stretches, one long hold-off
  initial begin
    int r;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst)
      @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 85) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 95) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(5, 20)) @(posedge clk);
        end else begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(100, 200)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (exp_words.size() == 0) begin
        $error("unexpected digest word %h index %0d", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = exp_words.pop_front();
        words_checked++;
        if (m_axis_tdata !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_word: expected %0d, got %0d", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[sha1_message_digest] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    int len;
    msgs_done     = 0;
    items_sent    = 0;
    hold_req      = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    load_iv();
    for (int i = 0; i < 16; i++)
      sched[i] = 32'd0;
    blk_bytes = 6'd0;
    bit_len   = 64'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_req(dir_rows[i].data, dir_rows[i].has, dir_rows[i].last,
               dir_rows[i].typed, dir_rows[i].digest);

    // random messages, starting while the receiver holds off
    hold_req = 1'b1;
    while (items_sent < NUM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r < 12)
        len = $urandom_range(0, 10);
      else if (r < 19)
        len = $urandom_range(52, 66);   // around the long tail and block edges
      else
        len = $urandom_range(110, 130);
      if (len > NUM_ITEMS - items_sent)
        len = NUM_ITEMS - items_sent;
      send_message(len);
    end
    s_axis_tvalid <= 1'b0;

    while (exp_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d messages, %0d digest words checked, %0d errors",
             msgs_done, words_checked, errors);
    if (errors == 0)
      $display("[sha1_message_digest] OK");
    else
      $display("[sha1_message_digest] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_dp.sv
hw/rtl/sha1md_ctrl.sv
hw/rtl/sha1_message_digest.sv
tb/tb.sv
